### hw/rtl/kf2_pkg.sv
// kf2_pkg: constants, register indexes and fixed-point helpers for the
// two-state kalman filter. no dependencies.
`default_nettype none
package kf2_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DT_W      = 25;
  localparam int NOISE_W   = 10;
  localparam int JIT_W     = 10;
  localparam int ACC_W     = 66;
  localparam int WIDE_W    = 68;

  localparam int REG_TIME_STEP   = 0;
  localparam int REG_NOISE_LEVEL = 1;

  localparam logic [DT_W-1:0]    DT_RESET    = DT_W'(65536);
  localparam logic [NOISE_W-1:0] NOISE_RESET = NOISE_W'(10);

  localparam logic signed [31:0]       QMAX      = 32'sh7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] WIDE_QMAX = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] WIDE_HALF = WIDE_W'(64'sd1) <<< (FRAC_BITS - 1);
  localparam logic signed [WIDE_W-1:0] WIDE_HALF1 = WIDE_W'(64'sd1) <<< FRAC_BITS;

  typedef logic signed [31:0] q_t;

  // symmetric clamp to the 32 bit range
  function automatic q_t sat32(input logic signed [WIDE_W-1:0] v);
    q_t r;
    if (v > WIDE_QMAX) begin
      r = QMAX;
    end else if (v < -WIDE_QMAX) begin
      r = -QMAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // round half up, shift by FRAC_BITS
  function automatic logic signed [WIDE_W-1:0] rnd_q(input logic signed [WIDE_W-1:0] v);
    return (v + WIDE_HALF) >>> FRAC_BITS;
  endfunction

  // round half up, shift by FRAC_BITS + 1
  function automatic logic signed [WIDE_W-1:0] rnd_q1(input logic signed [WIDE_W-1:0] v);
    return (v + WIDE_HALF1) >>> (FRAC_BITS + 1);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/kf2_mul.sv
// kf2_mul: bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
// depends on nothing but itself.
`default_nettype none
module kf2_mul (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire  signed [31:0] a,
  input  wire  signed [31:0] b,
  output logic               done,
  output logic signed [63:0] prod
);

  logic [31:0] ua_r;
  logic [63:0] p_r;
  logic        neg_r;
  logic        run_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] ua;
  logic [31:0] ub;
  logic [32:0] sum;

  assign ua  = a[31] ? 32'(-a) : 32'(a);
  assign ub  = b[31] ? 32'(-b) : 32'(b);
  assign sum = {1'b0, p_r[63:32]} + (p_r[0] ? {1'b0, ua_r} : 33'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      ua_r   <= ua;
      p_r    <= {32'd0, ub};
      neg_r  <= a[31] ^ b[31];
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      p_r   <= {sum, p_r[31:1]};
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign prod = neg_r ? -$signed(p_r) : $signed(p_r);

endmodule
`default_nettype wire

### hw/rtl/kf2_div.sv
// kf2_div: bit-serial restoring divider, sat(round(num * 2^FRAC_BITS / den)).
// also gives the raw quotient with FRAC_BITS+1 fraction bits. uses kf2_pkg.
`default_nettype none
module kf2_div (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  input  wire  signed [kf2_pkg::ACC_W-1:0]    num,
  input  wire  signed [kf2_pkg::ACC_W-1:0]    den,
  output logic                                done,
  output logic signed [31:0]                  quot,
  output logic [32+kf2_pkg::FRAC_BITS-1:0]    quot_raw
);

  localparam int SB = kf2_pkg::FRAC_BITS + 1;
  localparam int QB = 31 + SB;
  localparam int CW = $clog2(QB);

  logic [63:0]    d_r;
  logic [63:0]    rem_r;
  logic [QB-1:0]  sh_r;
  logic           neg_r;
  logic           big_r;
  logic           zero_r;
  logic           run_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;

  logic [63:0]    n;
  logic [63:0]    d;
  logic           big;
  logic [64:0]    t;
  logic           ge;
  logic [QB:0]    qr;
  logic [31:0]    qmag;

  assign n   = num[kf2_pkg::ACC_W-1] ? 64'(-num) : 64'(num);
  assign d   = den[kf2_pkg::ACC_W-1] ? 64'(-den) : 64'(den);
  assign big = (d[63:33] == '0) && (n >= {d[32:0], 31'd0});
  assign t   = {rem_r, sh_r[QB-1]};
  assign ge  = t >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      d_r    <= d;
      rem_r  <= {31'd0, n[63:31]};
      sh_r   <= {n[30:0], {SB{1'b0}}};
      neg_r  <= num[kf2_pkg::ACC_W-1] ^ den[kf2_pkg::ACC_W-1];
      big_r  <= big;
      zero_r <= (d == '0);
      cnt_r  <= '0;
      // overflowing quotient needs no iterations
      run_r  <= !big && (d != '0);
      done_r <= big || (d == '0);
    end else if (run_r) begin
      rem_r <= ge ? 64'(t - {1'b0, d_r}) : t[63:0];
      sh_r  <= {sh_r[QB-2:0], ge};
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(QB - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign qr = ({1'b0, sh_r} + (QB+1)'(1)) >> 1;

  always_comb begin
    if (big_r || (qr > (QB+1)'(kf2_pkg::QMAX))) begin
      qmag = 32'(kf2_pkg::QMAX);
    end else begin
      qmag = qr[31:0];
    end
    if (zero_r) begin
      quot = '0;
    end else begin
      quot = neg_r ? -$signed(qmag) : $signed(qmag);
    end
  end

  assign done     = done_r;
  assign quot_raw = sh_r;

endmodule
`default_nettype wire

### hw/rtl/kalman_filter_2state_top.sv
// kalman_filter_2state_top: position/velocity kalman filter with stream ports
// and a register port. uses kf2_pkg, kf2_mul and kf2_div.
`default_nettype none
// One input beat runs one predict/update step of a two-state kalman filter
// and yields one output beat with the new position, velocity and covariance
// (Q16.16, saturated); tuser is set when the innovation determinant was zero
// and the state was held. All arithmetic goes through one bit-serial
// multiplier and one bit-serial divider, which skips its iterations when a
// gain overflows and saturates, both driven by a step sequencer. A regular
// update takes 30 products, 5 divisions and 5 steps that use neither unit;
// a singular update stops after 10 products and 1 division. The next input
// beat is taken once the result sits in the output register; a result
// still waiting there holds the sequencer in its output step.
module kalman_filter_2state_top (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // pos_obs[31:0], vel_obs[63:32], accel[95:64], jitter[105:96], zero pad
  input  wire  [111:0] in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // pos_est, vel_est, cov_pp, cov_pv, cov_vp, cov_vv, 32 bits each from bit 0
  output logic [191:0] out_tdata,
  // singular
  output logic         out_tuser,
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [2:0]   cfg_paddr,
  input  wire  [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int F  = kf2_pkg::FRAC_BITS;
  localparam int AW = kf2_pkg::ACC_W;
  localparam int WW = kf2_pkg::WIDE_W;

  localparam logic [5:0] ST_IDLE = 6'd0,  ST_JQ   = 6'd1,  ST_C0   = 6'd2,
                         ST_XE0A = 6'd3,  ST_XE0B = 6'd4,  ST_XE1  = 6'd5,
                         ST_A00  = 6'd6,  ST_A10  = 6'd7,  ST_E0   = 6'd8,
                         ST_E1   = 6'd9,  ST_SUM  = 6'd10, ST_DETA = 6'd11,
                         ST_DETB = 6'd12, ST_DCHK = 6'd13, ST_N00A = 6'd14,
                         ST_N00B = 6'd15, ST_K00  = 6'd16, ST_N01A = 6'd17,
                         ST_N01B = 6'd18, ST_K01  = 6'd19, ST_N10A = 6'd20,
                         ST_N10B = 6'd21, ST_K10  = 6'd22, ST_N11A = 6'd23,
                         ST_N11B = 6'd24, ST_K11  = 6'd25, ST_Y    = 6'd26,
                         ST_PA   = 6'd27, ST_PB   = 6'd28, ST_VA   = 6'd29,
                         ST_VB   = 6'd30, ST_P0A  = 6'd31, ST_P0B  = 6'd32,
                         ST_P1A  = 6'd33, ST_P1B  = 6'd34, ST_P2A  = 6'd35,
                         ST_P2B  = 6'd36, ST_P3A  = 6'd37, ST_P3B  = 6'd38,
                         ST_OUT  = 6'd39;

  logic [kf2_pkg::DT_W-1:0]    time_step_r;
  logic [kf2_pkg::NOISE_W-1:0] noise_level_r;

  logic [5:0]  pc_r;
  logic        busy_r;
  logic        sing_r;
  logic        out_valid_r;
  logic [191:0] out_data_r;
  logic        out_sing_r;

  kf2_pkg::q_t pos_r, vel_r, cov0_r, cov1_r, cov2_r, cov3_r;
  kf2_pkg::q_t z0_r, z1_r, acl_r;
  logic [kf2_pkg::JIT_W-1:0] jit_r;
  kf2_pkg::q_t q_r, c0_r, xe0_r, xe1_r, a00_r, a10_r;
  kf2_pkg::q_t e0_r, e1_r, e2_r, e3_r, s00_r, s01_r, s10_r, s11_r;
  kf2_pkg::q_t k00_r, k01_r, k10_r, k11_r, y0_r, y1_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] det_r;

  logic               is_mul, is_div, mul_first, mul_sub;
  kf2_pkg::q_t        mul_a, mul_b;
  logic               mul_done, div_done;
  logic signed [63:0] prod;
  logic signed [AW-1:0] acc_w;
  logic signed [WW-1:0] r_w;
  logic signed [AW-1:0] div_num, div_den;
  kf2_pkg::q_t        div_q;
  logic [32+F-1:0]    div_raw;
  kf2_pkg::q_t        dt_q, nq_q, jq_q;
  logic               in_acc, cfg_wr;

  assign dt_q   = $signed(32'(time_step_r));
  assign nq_q   = $signed(32'({noise_level_r, {F{1'b0}}}));
  assign jq_q   = $signed(32'(div_raw >> (F + 1)));
  assign in_acc = in_tvalid && in_tready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // operand routing per step
  always_comb begin
    is_mul = 1'b1; is_div = 1'b0; mul_first = 1'b1; mul_sub = 1'b0;
    mul_a = dt_q; mul_b = dt_q;
    case (pc_r)
      ST_C0:   begin mul_a = dt_q; mul_b = dt_q; end
      ST_XE0A: begin mul_a = dt_q; mul_b = vel_r; end
      ST_XE0B: begin mul_a = c0_r; mul_b = acl_r; mul_first = 1'b0; end
      ST_XE1:  begin mul_a = dt_q; mul_b = acl_r; end
      ST_A00:  begin mul_a = dt_q; mul_b = cov1_r; end
      ST_A10:  begin mul_a = dt_q; mul_b = cov3_r; end
      ST_E0:   begin mul_a = dt_q; mul_b = a10_r; end
      ST_E1:   begin mul_a = dt_q; mul_b = cov3_r; end
      ST_DETA: begin mul_a = s00_r; mul_b = s11_r; end
      ST_DETB: begin mul_a = s01_r; mul_b = s10_r; mul_first = 1'b0; mul_sub = 1'b1; end
      ST_N00A: begin mul_a = e0_r; mul_b = s11_r; end
      ST_N00B: begin mul_a = e1_r; mul_b = s10_r; mul_first = 1'b0; mul_sub = 1'b1; end
      ST_N01A: begin mul_a = e1_r; mul_b = s00_r; end
      ST_N01B: begin mul_a = e0_r; mul_b = s01_r; mul_first = 1'b0; mul_sub = 1'b1; end
      ST_N10A: begin mul_a = e2_r; mul_b = s11_r; end
      ST_N10B: begin mul_a = e3_r; mul_b = s10_r; mul_first = 1'b0; mul_sub = 1'b1; end
      ST_N11A: begin mul_a = e3_r; mul_b = s00_r; end
      ST_N11B: begin mul_a = e2_r; mul_b = s01_r; mul_first = 1'b0; mul_sub = 1'b1; end
      ST_PA:   begin mul_a = k00_r; mul_b = y0_r; end
      ST_PB:   begin mul_a = k01_r; mul_b = y1_r; mul_first = 1'b0; end
      ST_VA:   begin mul_a = k10_r; mul_b = y0_r; end
      ST_VB:   begin mul_a = k11_r; mul_b = y1_r; mul_first = 1'b0; end
      ST_P0A:  begin mul_a = k00_r; mul_b = e0_r; end
      ST_P0B:  begin mul_a = k01_r; mul_b = e2_r; mul_first = 1'b0; end
      ST_P1A:  begin mul_a = k00_r; mul_b = e1_r; end
      ST_P1B:  begin mul_a = k01_r; mul_b = e3_r; mul_first = 1'b0; end
      ST_P2A:  begin mul_a = k10_r; mul_b = e0_r; end
      ST_P2B:  begin mul_a = k11_r; mul_b = e2_r; mul_first = 1'b0; end
      ST_P3A:  begin mul_a = k10_r; mul_b = e1_r; end
      ST_P3B:  begin mul_a = k11_r; mul_b = e3_r; mul_first = 1'b0; end
      ST_JQ, ST_K00, ST_K01, ST_K10, ST_K11: begin is_mul = 1'b0; is_div = 1'b1; end
      default: is_mul = 1'b0;
    endcase
  end

  assign acc_w = mul_first ? AW'(prod) :
                 (mul_sub ? acc_r - AW'(prod) : acc_r + AW'(prod));
  assign r_w   = kf2_pkg::rnd_q(WW'(acc_w));

  assign div_num = (pc_r == ST_JQ) ? $signed(AW'({jit_r, {F{1'b0}}}) + AW'(500)) : acc_r;
  assign div_den = (pc_r == ST_JQ) ? $signed(AW'(1000)) : det_r;

  kf2_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (is_mul && !busy_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  kf2_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (is_div && !busy_r),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quot     (div_q),
    .quot_raw (div_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r   <= kf2_pkg::DT_RESET;
      noise_level_r <= kf2_pkg::NOISE_RESET;
      pc_r          <= ST_IDLE;
      busy_r        <= 1'b0;
      sing_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      pos_r <= '0; vel_r <= '0;
      cov0_r <= '0; cov1_r <= '0; cov2_r <= '0; cov3_r <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[2])
          1'(kf2_pkg::REG_TIME_STEP):   time_step_r   <= cfg_pwdata[kf2_pkg::DT_W-1:0];
          1'(kf2_pkg::REG_NOISE_LEVEL): noise_level_r <= cfg_pwdata[kf2_pkg::NOISE_W-1:0];
          default: ;
        endcase
      end
      // the output step reloads the register itself
      if (out_valid_r && out_tready && (pc_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      if (is_mul || is_div) begin
        if (!busy_r) begin
          busy_r <= 1'b1;
        end else if (is_mul && mul_done) begin
          busy_r <= 1'b0;
          acc_r  <= acc_w;
          pc_r   <= pc_r + 6'd1;
          case (pc_r)
            ST_C0:   c0_r  <= kf2_pkg::sat32(kf2_pkg::rnd_q1(WW'(acc_w)));
            ST_XE0B: xe0_r <= kf2_pkg::sat32(WW'(pos_r) + r_w);
            ST_XE1:  xe1_r <= kf2_pkg::sat32(WW'(vel_r) + r_w);
            ST_A00:  a00_r <= kf2_pkg::sat32(WW'(cov0_r) + r_w);
            ST_A10:  a10_r <= kf2_pkg::sat32(WW'(cov2_r) + r_w);
            ST_E0: begin
              e0_r <= kf2_pkg::sat32(WW'(a00_r) + r_w + WW'(q_r));
              e2_r <= kf2_pkg::sat32(WW'(a10_r) + WW'(q_r));
            end
            ST_E1: begin
              e1_r <= kf2_pkg::sat32(WW'(cov1_r) + r_w + WW'(q_r));
              e3_r <= kf2_pkg::sat32(WW'(cov3_r) + WW'(q_r));
            end
            ST_DETB: det_r  <= acc_w;
            ST_PB:   pos_r  <= kf2_pkg::sat32(WW'(xe0_r) + r_w);
            ST_VB:   vel_r  <= kf2_pkg::sat32(WW'(xe1_r) + r_w);
            ST_P0B:  cov0_r <= kf2_pkg::sat32(WW'(e0_r) - r_w);
            ST_P1B:  cov1_r <= kf2_pkg::sat32(WW'(e1_r) - r_w);
            ST_P2B:  cov2_r <= kf2_pkg::sat32(WW'(e2_r) - r_w);
            ST_P3B:  cov3_r <= kf2_pkg::sat32(WW'(e3_r) - r_w);
            default: ;
          endcase
        end else if (is_div && div_done) begin
          busy_r <= 1'b0;
          pc_r   <= pc_r + 6'd1;
          case (pc_r)
            ST_JQ:  q_r   <= nq_q + jq_q;
            ST_K00: k00_r <= div_q;
            ST_K01: k01_r <= div_q;
            ST_K10: k10_r <= div_q;
            ST_K11: k11_r <= div_q;
            default: ;
          endcase
        end
      end else begin
        case (pc_r)
          ST_IDLE: begin
            if (in_acc) begin
              z0_r   <= kf2_pkg::sat32(WW'($signed(in_tdata[31:0])));
              z1_r   <= kf2_pkg::sat32(WW'($signed(in_tdata[63:32])));
              acl_r  <= kf2_pkg::sat32(WW'($signed(in_tdata[95:64])));
              jit_r  <= in_tdata[96 +: kf2_pkg::JIT_W];
              sing_r <= 1'b0;
              pc_r   <= ST_JQ;
            end
          end
          ST_SUM: begin
            s00_r <= kf2_pkg::sat32(WW'(e0_r) + WW'(q_r));
            s01_r <= kf2_pkg::sat32(WW'(e1_r) + WW'(nq_q));
            s10_r <= kf2_pkg::sat32(WW'(e2_r) + WW'(nq_q));
            s11_r <= kf2_pkg::sat32(WW'(e3_r) + WW'(nq_q));
            pc_r  <= ST_DETA;
          end
          ST_DCHK: begin
            // singular innovation: keep the state as it is
            if (det_r == '0) begin
              sing_r <= 1'b1;
              pc_r   <= ST_OUT;
            end else begin
              pc_r <= ST_N00A;
            end
          end
          ST_Y: begin
            y0_r <= kf2_pkg::sat32(WW'(z0_r) - WW'(xe0_r));
            y1_r <= kf2_pkg::sat32(WW'(z1_r) - WW'(xe1_r));
            pc_r <= ST_PA;
          end
          ST_OUT: begin
            if (!out_valid_r || out_tready) begin
              out_valid_r <= 1'b1;
              out_data_r  <= {cov3_r, cov2_r, cov1_r, cov0_r, vel_r, pos_r};
              out_sing_r  <= sing_r;
              pc_r        <= ST_IDLE;
            end
          end
          default: pc_r <= ST_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      1'(kf2_pkg::REG_TIME_STEP):   cfg_prdata = 32'(time_step_r);
      1'(kf2_pkg::REG_NOISE_LEVEL): cfg_prdata = 32'(noise_level_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign in_tready  = (pc_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sing_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (pc_r == ST_JQ))
    else $error("accepted beat did not start the sequence");

  a_mul_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> busy_r)
    else $error("multiplier finished with no product pending");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r == ST_OUT))
    else $error("output beat raised outside the output step");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
// testbench for kalman_filter_2state_top: directed and random observation
// beats checked against a bit-exact fixed-point filter predictor.
// depends on kf2_pkg and the rtl under hw/rtl.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] w_t;
  typedef struct {
    logic [31:0] f [6];
    logic        sing;
  } est_t;

  localparam int FRAC_BITS = kf2_pkg::FRAC_BITS;
  localparam w_t QM = w_t'(64'sd2147483647);
  localparam longint LIMIT = 40_000_000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [191:0] out_tdata;
  logic         out_tuser;
  logic         cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  kalman_filter_2state_top uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // filter state mirrored from the block
  w_t          f_pos, f_vel;
  w_t          f_cov [4];
  logic [24:0] f_dt;
  logic [9:0]  f_noise;

  est_t   est_q [$];
  int     errors = 0;
  int     n_sent = 0, n_got = 0, n_sing = 0;
  longint cycles = 0;
  bit     idle_on = 1;
  int     hold_off = 0;

  function automatic w_t sat(w_t v);
    if (v > QM) return QM;
    if (v < -QM) return -QM;
    return v;
  endfunction

  // round half up
  function automatic w_t rsh(w_t x, int s);
    return (x + (w_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic w_t obs(logic [31:0] v);
    return sat(w_t'($signed(v)));
  endfunction

  // gain entry: round(num * 2^F / den) half away from zero, saturated
  function automatic w_t gain_div(w_t num, w_t den);
    bit neg;
    w_t n, d, q;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    if (d == 0) return 0;
    q = n / d;
    if (q >= (w_t'(1) <<< 31)) q = QM;
    else begin
      q = (((n <<< (FRAC_BITS + 1)) / d) + 1) >>> 1;
      if (q > QM) q = QM;
    end
    return neg ? -q : q;
  endfunction

  function automatic est_t kalman_step(logic [111:0] d);
    est_t r;
    w_t z0, z1, a, dt, nq, jq, q, c0, xe0, xe1, a00, a01, a10, a11;
    w_t s00, s01, s10, s11, det, k00, k01, k10, k11, y0, y1;
    w_t e [4];
    w_t pn [4];
    z0 = obs(d[31:0]);
    z1 = obs(d[63:32]);
    a  = obs(d[95:64]);
    dt = w_t'(f_dt);
    nq = w_t'(f_noise) <<< FRAC_BITS;
    jq = ((w_t'(d[105:96]) <<< FRAC_BITS) + 500) / 1000;
    q  = nq + jq;
    c0  = sat(rsh(dt * dt, FRAC_BITS + 1));
    xe0 = sat(f_pos + rsh(dt * f_vel + c0 * a, FRAC_BITS));
    xe1 = sat(f_vel + rsh(dt * a, FRAC_BITS));
    a00 = sat(f_cov[0] + rsh(dt * f_cov[1], FRAC_BITS));
    a01 = f_cov[1];
    a10 = sat(f_cov[2] + rsh(dt * f_cov[3], FRAC_BITS));
    a11 = f_cov[3];
    e[0] = sat(a00 + rsh(dt * a10, FRAC_BITS) + q);
    e[1] = sat(a01 + rsh(dt * a11, FRAC_BITS) + q);
    e[2] = sat(a10 + q);
    e[3] = sat(a11 + q);
    s00 = sat(e[0] + q);
    s01 = sat(e[1] + nq);
    s10 = sat(e[2] + nq);
    s11 = sat(e[3] + nq);
    det = s00 * s11 - s01 * s10;
    r.sing = (det == 0);
    if (!r.sing) begin
      k00 = gain_div(e[0] * s11 - e[1] * s10, det);
      k01 = gain_div(e[1] * s00 - e[0] * s01, det);
      k10 = gain_div(e[2] * s11 - e[3] * s10, det);
      k11 = gain_div(e[3] * s00 - e[2] * s01, det);
      y0 = sat(z0 - xe0);
      y1 = sat(z1 - xe1);
      f_pos = sat(xe0 + rsh(k00 * y0 + k01 * y1, FRAC_BITS));
      f_vel = sat(xe1 + rsh(k10 * y0 + k11 * y1, FRAC_BITS));
      for (int j = 0; j < 2; j++) begin
        pn[j]     = sat(e[j] - rsh(k00 * e[j] + k01 * e[2 + j], FRAC_BITS));
        pn[2 + j] = sat(e[2 + j] - rsh(k10 * e[j] + k11 * e[2 + j], FRAC_BITS));
      end
      for (int i = 0; i < 4; i++) f_cov[i] = pn[i];
    end
    r.f[0] = f_pos[31:0];
    r.f[1] = f_vel[31:0];
    for (int i = 0; i < 4; i++) r.f[2 + i] = f_cov[i][31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, est_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    est_t ex;
    static string nm [7] = '{"pos_est", "vel_est", "cov_pp", "cov_pv", "cov_vp",
                             "cov_vv", "singular"};
    if (rst_n && out_tvalid && out_tready) begin
      n_got++;
      if (est_q.size() == 0) begin
        if (errors < 10) $display("unexpected result beat at cycle %0d", cycles);
        errors++;
      end else begin
        ex = est_q.pop_front();
        for (int i = 0; i < 7; i++) begin
          logic [31:0] got, want;
          got  = i < 6 ? out_tdata[32*i +: 32] : {31'd0, out_tuser};
          want = i < 6 ? ex.f[i] : {31'd0, ex.sing};
          if (got !== want) begin
            if (errors < 10)
              $display("result %0d %s: expected %h got %h", n_got, nm[i], want, got);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stall per beat, plus a long hold-off on request
  int stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_tready <= 0;
    end else if (out_tvalid && out_tready) begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      out_tready <= (stall == 0);
    end else if (stall > 0) begin
      stall--;
      out_tready <= (stall == 0);
    end else begin
      out_tready <= 1;
    end
  end

  task automatic send_obs(logic [31:0] p, logic [31:0] v, logic [31:0] a, logic [9:0] j);
    int g;
    g = idle_on ? $urandom_range(0, 5) : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {6'd0, j, a, v, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    est_q.push_back(kalman_step({6'd0, j, a, v, p}));
    if (est_q[$].sing) n_sing++;
    n_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 0;
    while (est_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(int idx, logic [31:0] val);
    drain();
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 3'(4 * idx); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (idx == kf2_pkg::REG_TIME_STEP) f_dt = val[24:0];
    else f_noise = val[9:0];
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
    endcase
  endfunction

  task automatic send_rand(int n);
    for (int i = 0; i < n; i++)
      send_obs(rand_q(), rand_q(), $urandom_range(0, 7) == 0 ? rand_q() : $urandom_range(0, 4096),
               10'($urandom_range(0, 1023)));
  endtask

  // zero covariance and zero noise give a zero determinant
  task automatic test_singular_from_reset;
    reg_write(kf2_pkg::REG_NOISE_LEVEL, 0);
    send_obs(32'h0001_0000, 32'h0000_8000, 32'h0, 0);
    send_obs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0);
    send_obs(32'h0, 32'h0, 32'h0, 1);
  endtask

  task automatic test_extremes;
    reg_write(kf2_pkg::REG_NOISE_LEVEL, 10);
    send_obs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 999);
    send_obs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_obs(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 1023);
    send_obs(32'h0, 32'h0, 32'h0, 500);
    send_obs(32'h0003_0000, 32'hFFFE_0000, 32'h0000_4000, 1);
    reg_write(kf2_pkg::REG_TIME_STEP, 0);
    send_obs(32'h0010_0000, 32'h0001_0000, 32'h7FFF_FFFF, 999);
    reg_write(kf2_pkg::REG_TIME_STEP, 32'h01FF_FFFF);
    send_obs(32'h0010_0000, 32'hFFFF_0000, 32'h8000_0000, 3);
    send_obs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1023);
    reg_write(kf2_pkg::REG_NOISE_LEVEL, 1023);
    send_obs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0);
  endtask

  task automatic test_register_sweep;
    logic [31:0] dts [5] = '{32'd1, 32'h0001_0000, 32'h0000_1000, 32'h0100_0000, 32'd0};
    logic [31:0] nls [4] = '{32'd0, 32'd1, 32'd1023, 32'd10};
    for (int i = 0; i < 5; i++) begin
      reg_write(kf2_pkg::REG_TIME_STEP, dts[i]);
      reg_write(kf2_pkg::REG_NOISE_LEVEL, nls[i % 4]);
      send_rand(30);
    end
    reg_write(kf2_pkg::REG_TIME_STEP, 32'h0001_0000);
  endtask

  task automatic test_output_backpressure;
    idle_on = 0;
    @(posedge clk);
    hold_off = 6000;
    send_rand(4);
    idle_on = 1;
  endtask

  task automatic test_random_stream;
    for (int blk = 0; blk < 20; blk++) begin
      idle_on = (blk % 5 != 3);
      if (blk % 7 == 6) reg_write(kf2_pkg::REG_TIME_STEP, $urandom_range(1, 2 ** 17));
      if (blk % 6 == 5) reg_write(kf2_pkg::REG_NOISE_LEVEL, $urandom_range(0, 1023));
      send_rand(90);
    end
    idle_on = 1;
  endtask

  initial begin
    f_pos = 0; f_vel = 0;
    for (int i = 0; i < 4; i++) f_cov[i] = 0;
    f_dt = kf2_pkg::DT_RESET;
    f_noise = kf2_pkg::NOISE_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_singular_from_reset();
    test_extremes();
    test_register_sweep();
    test_output_backpressure();
    test_random_stream();
    drain();
    repeat (1600) @(posedge clk);
    if (est_q.size() != 0) errors += est_q.size();
    $display("sent %0d observation beats, checked %0d results (%0d singular)",
             n_sent, n_got, n_sing);
    $display("covered register extremes, saturating inputs, stalls on both sides");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/kf2_pkg.sv
hw/rtl/kf2_mul.sv
hw/rtl/kf2_div.sv
hw/rtl/kalman_filter_2state_top.sv
tb/testbench.sv
